>>> rtl/core/particle_state_update_top_defines.svh
// ----------------------------------------------------------------------------
// Particle state update - assertion macros
// Shared property wrappers used by the top-level checks.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_STATE_UPDATE_TOP_DEFINES_SVH
`define PARTICLE_STATE_UPDATE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define PSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/psu_pkg.sv
// ----------------------------------------------------------------------------
// Particle state update package
// Field widths, record layouts, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int WORD_W      = 32;
  localparam int DT_W        = 17;
  localparam int AGE_W       = 31;
  localparam int IN_W        = 336;
  localparam int OUT_W       = 288;
  localparam int CFG_ADDR_W  = 3;
  localparam int PROD_W      = WORD_W + DT_W;   // signed word times step
  localparam int DRAG_PROD_W = AGE_W + DT_W;    // unsigned drag times step

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_GRAVITY_X   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRAVITY_Y   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GRAVITY_UP  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DRAG_RATE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_GROUND_MODE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_STICK_TIME  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_MODE = 3'd6;

  // Ground handling codes; the unused codes act as no handling
  localparam logic [1:0] GROUND_DIE   = 2'd1;
  localparam logic [1:0] GROUND_STICK = 2'd2;

  typedef enum logic [1:0] {
    KIND_DEAD,
    KIND_GROUNDED,
    KIND_FLYING
  } psu_kind_t;

  typedef struct packed {
    logic               screen_mode;
    logic [AGE_W-1:0]   stick_time;
    logic [1:0]         ground_mode;
    logic [AGE_W-1:0]   drag_rate;
    logic signed [31:0] gravity_up;
    logic signed [31:0] gravity_y;
    logic signed [31:0] gravity_x;
  } psu_cfg_t;

  // Input record, last field in the lowest bits
  typedef struct packed {
    logic               grounded_in;
    logic [AGE_W-1:0]   life_in;
    logic [AGE_W-1:0]   age_in;
    logic signed [31:0] spin_rate;
    logic signed [31:0] angle_in;
    logic signed [31:0] vel_up;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] height_in;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic [DT_W-1:0]    time_step;
  } psu_in_t;

  // Result record, last field in the lowest bits
  typedef struct packed {
    logic               new_grounded;
    logic [AGE_W-1:0]   new_life;
    logic [AGE_W-1:0]   new_age;
    logic signed [31:0] new_angle;
    logic signed [31:0] new_vel_up;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_height;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_x;
    logic               alive;
  } psu_out_t;

  // Classified item held in the queue
  typedef struct packed {
    psu_kind_t          kind;
    logic [AGE_W-1:0]   age;
    logic [AGE_W-1:0]   life;
    logic signed [31:0] spin_rate;
    logic signed [31:0] angle;
    logic signed [31:0] vel_up;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] height;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic [DT_W-1:0]    time_step;
  } psu_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } psu_qstat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Sum of two non-negative 31-bit values, clamped to the 31-bit range
  function automatic logic [AGE_W-1:0] addu31(input logic [AGE_W-1:0] a,
                                              input logic [AGE_W-1:0] b);
    logic [AGE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AGE_W] ? {AGE_W{1'b1}} : s[AGE_W-1:0];
  endfunction

endpackage

>>> rtl/core/psu_front.sv
// ----------------------------------------------------------------------------
// Particle state update - front end
// Accepts particle records, ages them and sorts them into dead, grounded
// or flying before they enter the queue.
// ----------------------------------------------------------------------------
module psu_front
  import psu_pkg::*;
(
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  psu_qstat_t       q_stat,
  output logic             q_push,
  output psu_entry_t       q_data
);

  psu_in_t          item;
  logic [AGE_W-1:0] age_new;
  logic             alive;

  assign item = s_tdata;

  // Take a transaction whenever the queue has room and reset is low
  assign s_tready = !q_stat.full && !rst;
  assign q_push   = s_tvalid && s_tready;

  // Age step and expiry check
  always_comb begin
    age_new = addu31(item.age_in, AGE_W'(item.time_step));
    alive   = age_new < item.life_in;
  end

  always_comb begin
    q_data.kind      = !alive ? KIND_DEAD : (item.grounded_in ? KIND_GROUNDED : KIND_FLYING);
    q_data.age       = age_new;
    q_data.life      = item.life_in;
    q_data.spin_rate = item.spin_rate;
    q_data.angle     = item.angle_in;
    q_data.vel_up    = item.vel_up;
    q_data.vel_y     = item.vel_y;
    q_data.vel_x     = item.vel_x;
    q_data.height    = item.height_in;
    q_data.pos_y     = item.pos_y;
    q_data.pos_x     = item.pos_x;
    q_data.time_step = item.time_step;
  end

endmodule

>>> rtl/core/psu_queue.sv
// ----------------------------------------------------------------------------
// Particle state update - item queue
// Short register queue between front end and integration pipeline.
// ----------------------------------------------------------------------------
module psu_queue
  import psu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  psu_entry_t push_data,
  input  logic       pop,
  output psu_entry_t pop_data,
  output psu_qstat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  psu_entry_t     slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign stat.full  = count == CW'(DEPTH);
  assign stat.empty = count == '0;
  assign pop_data   = slots[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/psu_back.sv
// ----------------------------------------------------------------------------
// Particle state update - integration pipeline
// Five-stage Euler step: gravity, damping, position, ground contact.
// ----------------------------------------------------------------------------
module psu_back
  import psu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  psu_cfg_t   cfg,
  input  psu_entry_t q_data,
  input  psu_qstat_t q_stat,
  output logic       q_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output psu_out_t   m_item
);

  localparam int DAMP_W = FRAC_BITS + 1;
  localparam int VPW    = WORD_W + DAMP_W + 1;

  // Stage valids and global advance
  logic va, vb, vc, vd;
  logic en;

  // Stage A: gravity, spin and drag products
  psu_entry_t                a_e;
  logic signed [PROD_W-1:0]  a_gprod [3];
  logic signed [PROD_W-1:0]  a_sprod;
  logic [DRAG_PROD_W-1:0]    a_dprod;

  // Stage B: gravity applied, damping factor, new angle
  psu_entry_t                b_e;
  logic signed [31:0]        b_vel [3];
  logic [DAMP_W-1:0]         b_damp;
  logic signed [31:0]        b_angle;

  // Stage C: damped velocity products
  psu_entry_t                c_e;
  logic signed [VPW-1:0]     c_vprod [3];
  logic signed [31:0]        c_angle;

  // Stage D: damped velocity and displacement products
  psu_entry_t                d_e;
  logic signed [31:0]        d_vel [3];
  logic signed [PROD_W-1:0]  d_pprod [3];
  logic signed [31:0]        d_angle;

  // Combinational stage values
  logic signed [31:0]        q_grav [3];
  logic signed [31:0]        a_vel [3];
  logic signed [PROD_W-1:0]  a_gsh [3];
  logic signed [PROD_W-1:0]  a_ssh;
  logic [DRAG_PROD_W-1:0]    drag_term;
  logic [DRAG_PROD_W-1:0]    one_w;
  logic signed [31:0]        b_vel_next [3];
  logic [DAMP_W-1:0]         damp_next;
  logic signed [31:0]        angle_next;
  logic signed [VPW-1:0]     c_vsh [3];
  logic signed [31:0]        d_vel_next [3];
  logic signed [PROD_W-1:0]  d_psh [3];
  logic signed [31:0]        d_pos [3];
  logic signed [31:0]        pos_next [3];
  logic                      contact;
  logic [AGE_W-1:0]          cut;
  psu_out_t                  res;

  assign en    = !m_tvalid || m_tready;
  assign q_pop = en && !q_stat.empty;

  assign q_grav[0] = cfg.gravity_x;
  assign q_grav[1] = cfg.gravity_y;
  assign q_grav[2] = cfg.gravity_up;

  assign a_vel[0] = a_e.vel_x;
  assign a_vel[1] = a_e.vel_y;
  assign a_vel[2] = a_e.vel_up;

  assign d_pos[0] = d_e.pos_x;
  assign d_pos[1] = d_e.pos_y;
  assign d_pos[2] = d_e.height;

  // Gravity add and damping factor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_gsh[i]      = a_gprod[i] >>> FRAC_BITS;
      b_vel_next[i] = sat32(64'(a_vel[i]) + 64'(sat32(64'(a_gsh[i]))));
    end
    a_ssh      = a_sprod >>> FRAC_BITS;
    angle_next = a_e.angle + a_ssh[31:0];
    drag_term  = a_dprod >> FRAC_BITS;
    one_w      = DRAG_PROD_W'(1) << FRAC_BITS;
    if (drag_term >= one_w) begin
      damp_next = '0;
    end else begin
      damp_next = DAMP_W'(one_w - drag_term);
    end
  end

  // Damped velocity
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_vsh[i]      = c_vprod[i] >>> FRAC_BITS;
      d_vel_next[i] = sat32(64'(c_vsh[i]));
    end
  end

  // Position update, ground contact and result assembly
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_psh[i]    = d_pprod[i] >>> FRAC_BITS;
      pos_next[i] = sat32(64'(d_pos[i]) + 64'(sat32(64'(d_psh[i]))));
    end
    contact = !cfg.screen_mode &&
              (cfg.ground_mode == GROUND_DIE || cfg.ground_mode == GROUND_STICK) &&
              (pos_next[2] <= 32'sd0);
    cut = addu31(d_e.age, cfg.stick_time);
    res = '0;
    unique case (d_e.kind)
      KIND_FLYING: begin
        if (!(contact && cfg.ground_mode == GROUND_DIE)) begin
          res.alive      = 1'b1;
          res.new_pos_x  = pos_next[0];
          res.new_pos_y  = pos_next[1];
          res.new_height = pos_next[2];
          res.new_vel_x  = d_vel[0];
          res.new_vel_y  = d_vel[1];
          res.new_vel_up = d_vel[2];
          res.new_angle  = d_angle;
          res.new_age    = d_e.age;
          res.new_life   = d_e.life;
          if (contact) begin
            res.new_height   = '0;
            res.new_vel_x    = '0;
            res.new_vel_y    = '0;
            res.new_vel_up   = '0;
            res.new_grounded = 1'b1;
            if (cut < d_e.life) begin
              res.new_life = cut;
            end
          end
        end
      end
      KIND_GROUNDED: begin
        res.alive        = 1'b1;
        res.new_pos_x    = d_e.pos_x;
        res.new_pos_y    = d_e.pos_y;
        res.new_height   = d_e.height;
        res.new_vel_x    = d_e.vel_x;
        res.new_vel_y    = d_e.vel_y;
        res.new_vel_up   = d_e.vel_up;
        res.new_angle    = d_angle;
        res.new_age      = d_e.age;
        res.new_life     = d_e.life;
        res.new_grounded = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Stage valids and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      vd       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      va       <= q_pop;
      vb       <= va;
      vc       <= vb;
      vd       <= vc;
      m_tvalid <= vd;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_e     <= q_data;
      for (int i = 0; i < 3; i++) begin
        a_gprod[i] <= PROD_W'(q_grav[i]) * PROD_W'($signed({1'b0, q_data.time_step}));
      end
      a_sprod <= PROD_W'(q_data.spin_rate) * PROD_W'($signed({1'b0, q_data.time_step}));
      a_dprod <= DRAG_PROD_W'(cfg.drag_rate) * DRAG_PROD_W'(q_data.time_step);

      b_e     <= a_e;
      b_vel   <= b_vel_next;
      b_damp  <= damp_next;
      b_angle <= angle_next;

      c_e     <= b_e;
      for (int i = 0; i < 3; i++) begin
        c_vprod[i] <= VPW'(b_vel[i]) * VPW'($signed({1'b0, b_damp}));
      end
      c_angle <= b_angle;

      d_e     <= c_e;
      d_vel   <= d_vel_next;
      for (int i = 0; i < 3; i++) begin
        d_pprod[i] <= PROD_W'(d_vel_next[i]) * PROD_W'($signed({1'b0, c_e.time_step}));
      end
      d_angle <= c_angle;

      m_item  <= res;
    end
  end

endmodule

>>> rtl/core/particle_state_update_top.sv
// ----------------------------------------------------------------------------
// Particle state update - top level
// One Euler integration step per particle record, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Input stream s_*: one particle record and its time step per transaction.
// Output stream m_*: the updated record, one result per input, in order.
// Configuration: cfg_we / cfg_addr / cfg_wdata write one register per cycle
// (gravity x, y, up, drag rate, ground mode, stick time, screen mode);
// write them only while no particle is in flight.
// Path: an accepted record is written into the queue, then moves through
// pipeline stages A, B, C and D and the output register to m_tvalid.
// Throughput: one record per cycle while m_tready does not stall the output,
// set by the fully pipelined multiply stages; the front end and the pipeline
// are split by a small queue.
// Reset: synchronous, clears config registers, queue and all stage valids.
// Stall: with m_tvalid high and m_tready low the pipeline freezes and holds
// its result; the queue keeps taking records until full, then s_tready drops.
// ----------------------------------------------------------------------------
`include "particle_state_update_top_defines.svh"

module particle_state_update_top
  import psu_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [WORD_W-1:0]     cfg_wdata,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata, low bit up: time_step, pos_x, pos_y, height_in, vel_x, vel_y,
  // vel_up, angle_in, spin_rate, age_in, life_in, grounded_in
  input  logic [IN_W-1:0]       s_tdata,
  // Output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata, low bit up: alive, new_pos_x, new_pos_y, new_height, new_vel_x,
  // new_vel_y, new_vel_up, new_angle, new_age, new_life, new_grounded
  output logic [OUT_W-1:0]      m_tdata
);

  psu_cfg_t   cfg;
  psu_qstat_t q_stat;
  psu_entry_t q_in;
  psu_entry_t q_out;
  logic       q_push;
  logic       q_pop;
  psu_out_t   m_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GRAVITY_X:   cfg.gravity_x   <= cfg_wdata;
        REG_GRAVITY_Y:   cfg.gravity_y   <= cfg_wdata;
        REG_GRAVITY_UP:  cfg.gravity_up  <= cfg_wdata;
        REG_DRAG_RATE:   cfg.drag_rate   <= cfg_wdata[AGE_W-1:0];
        REG_GROUND_MODE: cfg.ground_mode <= cfg_wdata[1:0];
        REG_STICK_TIME:  cfg.stick_time  <= cfg_wdata[AGE_W-1:0];
        REG_SCREEN_MODE: cfg.screen_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  psu_front u_front (
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  psu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  psu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_data   (q_out),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_item   (m_item)
  );

  assign m_tdata = m_item;

  // Checks
  `PSU_ASSERT_NOW(a_push_not_full, q_push, !q_stat.full, "queue written while full")
  `PSU_ASSERT_NOW(a_pop_not_empty, q_pop, !q_stat.empty, "queue read while empty")
  `PSU_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "queue lost a write")
  `PSU_ASSERT_NOW(a_dead_zero, m_tvalid && !m_item.alive, m_tdata == '0, "dead result not cleared")

endmodule

>>> verif/particle_state_update_top_test.sv
// ----------------------------------------------------------------------------
// Particle state update - stream testbench
// Streams particle records through the block under a series of register
// settings and compares every updated record, field by field, against a
// fixed-point Euler step computed here. A directed set covers expiry, dead
// results, grounded records, saturation, angle wrap, oversized steps and the
// ground die / stick / screen-space / unused-mode cases; a random set follows
// with bursty input, varied output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module particle_state_update_top_test;
  import psu_pkg::*;

  localparam int     QF                 = FRAC_BITS_DEF;
  localparam longint ONE_Q              = 64'sd1 << QF;
  localparam longint S32_HI             = 64'sd2147483647;
  localparam longint S32_LO             = -64'sd2147483648;
  localparam longint U31_HI             = 64'sd2147483647;
  localparam int     WATCHDOG_LIMIT     = 2000;
  localparam int     DRAIN_PAUSE        = 8;
  localparam int     HOLD_CYCLES        = 300;
  localparam int     RANDOM_PER_SETTING = 165;
  localparam int     NUM_RANDOM_SETS    = 8;

  // Ground codes without a name in the package
  localparam logic [1:0] GROUND_NONE  = 2'd0;
  localparam logic [1:0] GROUND_SPARE = 2'd3;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_CHOKED
  } sink_mode_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [WORD_W-1:0]     cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;

  // Register shadow used by the predictor
  longint     grav_x = 0, grav_y = 0, grav_up = 0;
  longint     drag_rate_q = 0, stick_time_q = 0;
  logic [1:0] ground_mode_q = GROUND_NONE;
  logic       screen_mode_q = 1'b0;

  psu_out_t   pending_updates[$];
  sink_mode_t rx_mode = SINK_OPEN;
  logic       hold_req = 1'b0;
  bit         src_gaps = 1'b1;
  int         burst_left = 0;
  int         fail_count = 0;
  int         records_sent = 0;
  int         results_checked = 0;
  int         dead_seen = 0;
  int         pinned_seen = 0;
  int         input_stall_cycles = 0;
  int         settings_loaded = 0;

  particle_state_update_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp_s32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic longint clamp_u31(input longint v);
    if (v > U31_HI) return U31_HI;
    if (v < 0) return 0;
    return v;
  endfunction

  // exact product, then floor shift
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> QF;
  endfunction

  function automatic psu_out_t advance_particle(input psu_in_t rec);
    longint      step, px, py, ht, vx, vy, vz, age, life, damp, cut;
    logic [31:0] ang;
    logic        pinned, alive;
    psu_out_t    res;
    step   = longint'(rec.time_step);
    px     = longint'($signed(rec.pos_x));
    py     = longint'($signed(rec.pos_y));
    ht     = longint'($signed(rec.height_in));
    vx     = longint'($signed(rec.vel_x));
    vy     = longint'($signed(rec.vel_y));
    vz     = longint'($signed(rec.vel_up));
    ang    = rec.angle_in;
    life   = longint'(rec.life_in);
    pinned = rec.grounded_in;
    age    = clamp_u31(longint'(rec.age_in) + step);
    alive  = (age < life);

    if (alive) begin
      // rotation wraps, increment taken modulo 2^32
      ang = ang + 32'(qmul(longint'($signed(rec.spin_rate)), step));
      if (!pinned) begin
        damp = ONE_Q;
        if (drag_rate_q > 0) begin
          damp = ONE_Q - qmul(drag_rate_q, step);
          if (damp < 0) damp = 0;
        end
        vx = clamp_s32(vx + clamp_s32(qmul(grav_x, step)));
        vy = clamp_s32(vy + clamp_s32(qmul(grav_y, step)));
        vz = clamp_s32(vz + clamp_s32(qmul(grav_up, step)));
        vx = clamp_s32(qmul(vx, damp));
        vy = clamp_s32(qmul(vy, damp));
        vz = clamp_s32(qmul(vz, damp));
        px = clamp_s32(px + clamp_s32(qmul(vx, step)));
        py = clamp_s32(py + clamp_s32(qmul(vy, step)));
        ht = clamp_s32(ht + clamp_s32(qmul(vz, step)));

        // ground contact, world space only
        if (!screen_mode_q && ht <= 0 &&
            (ground_mode_q == GROUND_DIE || ground_mode_q == GROUND_STICK)) begin
          ht = 0;
          if (ground_mode_q == GROUND_DIE) begin
            alive = 1'b0;
          end else begin
            cut    = clamp_u31(age + stick_time_q);
            pinned = 1'b1;
            vx     = 0;
            vy     = 0;
            vz     = 0;
            if (cut < life) life = cut;
          end
        end
      end
    end

    res = '0;
    if (alive) begin
      res.alive        = 1'b1;
      res.new_pos_x    = px[31:0];
      res.new_pos_y    = py[31:0];
      res.new_height   = ht[31:0];
      res.new_vel_x    = vx[31:0];
      res.new_vel_y    = vy[31:0];
      res.new_vel_up   = vz[31:0];
      res.new_angle    = ang;
      res.new_age      = age[AGE_W-1:0];
      res.new_life     = life[AGE_W-1:0];
      res.new_grounded = pinned;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Record builders
  // --------------------------------------------------------------------------
  function automatic psu_in_t make_particle(
    input logic [DT_W-1:0]  dt,
    input logic [31:0]      px, py, ht, vx, vy, vz, ang, spin,
    input logic [AGE_W-1:0] age, life,
    input logic             gnd
  );
    psu_in_t r;
    r.time_step   = dt;
    r.pos_x       = px;
    r.pos_y       = py;
    r.height_in   = ht;
    r.vel_x       = vx;
    r.vel_y       = vy;
    r.vel_up      = vz;
    r.angle_in    = ang;
    r.spin_rate   = spin;
    r.age_in      = age;
    r.life_in     = life;
    r.grounded_in = gnd;
    return r;
  endfunction

  function automatic logic [31:0] around_zero(input int unsigned half);
    return 32'($urandom_range(0, 2 * half)) - 32'(half);
  endfunction

  function automatic logic [31:0] near_limit();
    if ($urandom_range(0, 1)) return 32'h7fffffff - $urandom_range(0, 1 << 20);
    return 32'h80000000 + $urandom_range(0, 1 << 20);
  endfunction

  // Mostly plausible live particles; the rest oversized steps, noise, expiry edges, near-limit
  function automatic psu_in_t random_record();
    psu_in_t     r;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    r.time_step = (pick == 5) ? 17'($urandom_range(65537, 131071))
                              : 17'($urandom_range(0, 65536));
    r.pos_x       = around_zero(1 << 24);
    r.pos_y       = around_zero(1 << 24);
    r.height_in   = 32'($urandom_range(0, 1 << 22)) - 32'(1 << 18);
    r.vel_x       = around_zero(1 << 22);
    r.vel_y       = around_zero(1 << 22);
    r.vel_up      = around_zero(1 << 21);
    r.angle_in    = $urandom;
    r.spin_rate   = around_zero(1 << 20);
    r.age_in      = 31'($urandom_range(0, 1 << 20));
    r.life_in     = r.age_in + 31'($urandom_range(0, 1 << 21));
    r.grounded_in = ($urandom_range(0, 4) == 0);
    case (pick)
      6, 7: begin
        r.time_step   = 17'($urandom);
        r.pos_x       = $urandom;
        r.pos_y       = $urandom;
        r.height_in   = $urandom;
        r.vel_x       = $urandom;
        r.vel_y       = $urandom;
        r.vel_up      = $urandom;
        r.spin_rate   = $urandom;
        r.age_in      = 31'($urandom);
        r.life_in     = 31'($urandom);
        r.grounded_in = 1'($urandom);
        if (pick == 7) begin
          r.age_in  = 31'($urandom_range(0, 65535));
          r.life_in = 31'h7fffffff;
        end
      end
      8: r.life_in = r.age_in + 31'(r.time_step) + 31'($urandom_range(0, 2)) - 31'd1;
      9: begin
        r.pos_x     = near_limit();
        r.pos_y     = near_limit();
        r.height_in = near_limit();
        r.vel_x     = near_limit();
        r.vel_y     = near_limit();
        r.vel_up    = near_limit();
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one record, wait for the transaction, then maybe take a gap
  task automatic send_record(input psu_in_t rec);
    s_tdata  <= rec;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_updates = {pending_updates, advance_particle(rec)};
    records_sent++;
    if (src_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_GRAVITY_X:   grav_x        = longint'($signed(val));
      REG_GRAVITY_Y:   grav_y        = longint'($signed(val));
      REG_GRAVITY_UP:  grav_up       = longint'($signed(val));
      REG_DRAG_RATE:   drag_rate_q   = longint'(val[30:0]);
      REG_GROUND_MODE: ground_mode_q = val[1:0];
      REG_STICK_TIME:  stick_time_q  = longint'(val[30:0]);
      REG_SCREEN_MODE: screen_mode_q = val[0];
      default: ;
    endcase
  endtask

  // Load all registers, only once the pipeline is empty
  task automatic apply_settings(
    input logic [31:0]      gx, gy, gup,
    input logic [AGE_W-1:0] drag,
    input logic [1:0]       gmode,
    input logic [AGE_W-1:0] stick,
    input logic             smode
  );
    wait_drained();
    write_reg(REG_GRAVITY_X, gx);
    write_reg(REG_GRAVITY_Y, gy);
    write_reg(REG_GRAVITY_UP, gup);
    write_reg(REG_DRAG_RATE, 32'(drag));
    write_reg(REG_GROUND_MODE, 32'(gmode));
    write_reg(REG_STICK_TIME, 32'(stick));
    write_reg(REG_SCREEN_MODE, 32'(smode));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Output side pacing, with an optional long hold-off
  initial begin : sink_pacing
    int unsigned hold_cnt;
    int unsigned tick;
    hold_cnt = 0;
    tick     = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          SINK_OPEN:    m_tready <= 1'b1;
          SINK_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
          SINK_PATTERN: m_tready <= ((tick % 11) >= 3);
          default:      m_tready <= ($urandom_range(0, 4) < 2);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    psu_out_t want;
    psu_out_t got;
    if (!rst) begin
      if (s_tvalid && !s_tready) input_stall_cycles++;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_updates.size() == 0) begin
          $error("result transaction with no particle record pending: %h", m_tdata);
          fail_count++;
        end else begin
          want = pending_updates.pop_front();
          results_checked++;
          if (!want.alive) dead_seen++;
          if (want.new_grounded) pinned_seen++;
          check_field("alive", 32'(want.alive), 32'(got.alive));
          check_field("new_pos_x", want.new_pos_x, got.new_pos_x);
          check_field("new_pos_y", want.new_pos_y, got.new_pos_y);
          check_field("new_height", want.new_height, got.new_height);
          check_field("new_vel_x", want.new_vel_x, got.new_vel_x);
          check_field("new_vel_y", want.new_vel_y, got.new_vel_y);
          check_field("new_vel_up", want.new_vel_up, got.new_vel_up);
          check_field("new_angle", want.new_angle, got.new_angle);
          check_field("new_age", 32'(want.new_age), 32'(got.new_age));
          check_field("new_life", 32'(want.new_life), 32'(got.new_life));
          check_field("new_grounded", 32'(want.new_grounded), 32'(got.new_grounded));
        end
      end
    end
  end

  // Ends the run if neither stream moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: %0d cycles without a transaction", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Registers at reset: zero step, grounded record, saturation, wrap, big step
  task automatic test_reset_defaults();
    send_record(make_particle(17'd0, 0, 0, 0, 0, 0, 0, 0, 0, 31'd0, 31'd1, 1'b0));
    send_record(make_particle(17'h10000, 32'h12345678, 32'hedcba988, 32'h00020000,
                              32'hfff00000, 32'h00100000, 32'h7fffffff, 32'h7fffffff,
                              32'h7fffffff, 31'd0, 31'h7fffffff, 1'b1));
    send_record(make_particle(17'h10000, 32'h7fff0000, 32'h80010000, 32'h7fffffff,
                              32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                              32'h80000000, 31'd0, 31'h7fffffff, 1'b0));
    send_record(make_particle(17'h1ffff, 0, 0, 32'h00100000, 32'h00010000,
                              32'hffff0000, 32'h00008000, 0, 32'h00020000,
                              31'd1000, 31'h7fffffff, 1'b0));
  endtask

  // Age reaching lifetime, age saturation, one tick short of expiry
  task automatic test_expiry();
    send_record(make_particle(17'd32768, 32'h00010000, 32'h00020000, 32'h00030000,
                              32'h00040000, 32'h00050000, 32'h00060000, 32'h00070000,
                              32'h00080000, 31'd100000, 31'd132768, 1'b0));
    send_record(make_particle(17'h10000, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                              32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                              32'hffffffff, 31'h7fffffff, 31'h7fffffff, 1'b1));
    send_record(make_particle(17'd50, 32'h00010000, 0, 32'h00010000, 0, 0, 0, 0, 0,
                              31'd99, 31'd150, 1'b0));
  endtask

  // Extreme gravity with drag, and dying on ground contact
  task automatic test_ground_die();
    apply_settings(32'h7fffffff, 32'h80000000, 32'hfff63333, 31'd32768, GROUND_DIE,
                   31'd131072, 1'b0);
    send_record(make_particle(17'h10000, 0, 0, 32'h10000000, 32'h7fff0000,
                              32'h80000001, 0, 0, 0, 31'd0, 31'h7fffffff, 1'b0));
    send_record(make_particle(17'h10000, 0, 0, 32'h00010000, 0, 0, 32'hfffc0000, 0, 0,
                              31'd0, 31'h7fffffff, 1'b0));
    send_record(make_particle(17'd0, 0, 0, 0, 0, 0, 0, 0, 0, 31'd0, 31'd1, 1'b0));
    send_record(make_particle(17'd0, 0, 0, 32'd1, 0, 0, 0, 0, 0, 31'd0, 31'd1, 1'b0));
  endtask

  // Full drag, sticking with and without a lifetime cut, grounded pass-through
  task automatic test_ground_stick();
    apply_settings(0, 0, 0, 31'h7fffffff, GROUND_STICK, 31'd131072, 1'b0);
    send_record(make_particle(17'h10000, 0, 0, 32'hfffffffb, 32'h00050000, 0, 0, 0, 0,
                              31'd1000, 31'h7fffffff, 1'b0));
    send_record(make_particle(17'd10, 0, 0, 0, 0, 0, 0, 0, 0, 31'd1000, 31'd5000, 1'b0));
    send_record(make_particle(17'd16, 0, 0, 32'hffffffff, 0, 0, 0, 0, 0,
                              31'h7ffff000, 31'h7fffffff, 1'b0));
    send_record(make_particle(17'h10000, 32'h00010000, 0, 32'hffff0000, 32'h00030000,
                              0, 32'hffff0000, 0, 32'h00010000, 31'd0, 31'h7fffffff,
                              1'b1));
    send_record(make_particle(17'd0, 0, 0, 32'h00050000, 32'h00030000, 0, 0, 0, 0,
                              31'd0, 31'd10, 1'b0));
  endtask

  // Ground contact ignored in screen space and with the unused ground code
  task automatic test_screen_and_spare_modes();
    apply_settings(0, 0, 0, 31'd0, GROUND_STICK, 31'd131072, 1'b1);
    send_record(make_particle(17'h10000, 0, 0, 32'h80000000, 0, 0, 32'hffff0000, 0, 0,
                              31'd0, 31'h7fffffff, 1'b0));
    apply_settings(0, 0, 0, 31'd0, GROUND_SPARE, 31'd0, 1'b0);
    send_record(make_particle(17'h10000, 0, 0, 32'hfff00000, 0, 0, 32'hffff0000, 0, 0,
                              31'd0, 31'h7fffffff, 1'b0));
  endtask

  // Random records under a sweep of settings, with varied pacing
  task automatic test_random_settings();
    for (int p = 0; p < NUM_RANDOM_SETS; p++) begin
      case (p)
        0: apply_settings(0, 0, 0, 31'd0, GROUND_NONE, 31'd0, 1'b0);
        1: apply_settings(32'd1000, 32'hfffff830, 32'hfff63333, 31'd16384, GROUND_DIE,
                          31'd0, 1'b0);
        2: apply_settings(0, 32'd5000, 32'hfff63333, 31'd65536, GROUND_STICK,
                          31'd131072, 1'b0);
        3: apply_settings(32'hffff0000, 0, 32'hfff63333, 31'd8192, GROUND_STICK,
                          31'd65536, 1'b1);
        4: apply_settings(0, 0, 32'hfff63333, 31'd4096, GROUND_SPARE, 31'd65536, 1'b0);
        5: apply_settings(32'h7fffffff, 32'h80000000, 32'h80000000, 31'h7fffffff,
                          GROUND_STICK, 31'h7fffffff, 1'b0);
        6: apply_settings(32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'd1, GROUND_DIE,
                          31'd0, 1'b0);
        default: apply_settings($urandom, $urandom, $urandom, 31'($urandom),
                                2'($urandom_range(0, 3)), 31'($urandom),
                                1'($urandom_range(0, 1)));
      endcase
      rx_mode  = sink_mode_t'(p % 4);
      src_gaps = ((p % 3) != 2);
      repeat (RANDOM_PER_SETTING) send_record(random_record());
    end
  endtask

  // Long output hold-off while input keeps coming, so the input side backs up
  task automatic test_output_stall();
    apply_settings(32'd2000, 32'hfffff000, 32'hfff63333, 31'd16384, GROUND_STICK,
                   31'd32768, 1'b0);
    rx_mode  = SINK_RANDOM;
    src_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (80) send_record(random_record());
    src_gaps = 1'b1;
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = REG_GRAVITY_X;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_expiry();
    test_ground_die();
    test_ground_stick();
    test_screen_and_spare_modes();
    test_random_settings();
    test_output_stall();
    wait_drained();

    $display("Covered %0d particle records over %0d register loads; %0d results checked",
             records_sent, settings_loaded, results_checked);
    $display("(%0d dead, %0d pinned), input held off by back-pressure for %0d cycles.",
             dead_seen, pinned_seen, input_stall_cycles);
    if (fail_count == 0 && pending_updates.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
